@@ rtl/qde_pkg.sv @@
// qde_pkg: shared constants, types and helpers for the quantile digest engine
// used by every module under rtl; depends on nothing
`default_nettype none

package qde_pkg;

  localparam int KeyBits  = 10;
  localparam int NodeW    = KeyBits + 1;
  localparam int DepW     = $clog2(KeyBits + 1);
  localparam int MemDepth = 2 ** NodeW;
  localparam int CntW     = 32;
  localparam int KW       = 16;
  localparam int AmtW     = 16;
  localparam int FracW    = 17;
  localparam int ProdW    = FracW + CntW;
  localparam int AccW     = CntW + 1;
  localparam int KsixW    = KW + 3;
  localparam int DivCntW  = $clog2(CntW + 1);

  localparam logic [KW-1:0]    KReset  = KW'(16);
  localparam logic [FracW-1:0] FracOne = FracW'(65536);
  localparam logic [DepW-1:0]  KeyDep  = DepW'(KeyBits);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_END,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_Q_MUL,
    ST_Q_CHK,
    ST_T_DOWN,
    ST_T_LCHK,
    ST_T_RCHK,
    ST_T_VISIT,
    ST_T_UP,
    ST_T_SCHK,
    ST_Q_ADD,
    ST_C_RL,
    ST_C_RR,
    ST_C_DEC,
    ST_C_PS,
    ST_C_SK,
    ST_C_SKL,
    ST_C_SUM,
    ST_C_WI,
    ST_C_WS,
    ST_DONE
  } walk_state_e;

  typedef struct packed {
    logic            pres;
    logic [CntW-1:0] cnt;
  } node_t;

  typedef struct packed {
    logic             rd_en;
    logic [NodeW-1:0] rd_addr;
    logic             wr_en;
    logic [NodeW-1:0] wr_addr;
    node_t            wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [KeyBits-1:0] pval;
    logic [CntW-1:0]    total;
    logic [NodeW-1:0]   nodes;
    logic               comp;
  } result_t;

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? '1 : s[CntW-1:0];
  endfunction

  // largest key covered by a node: ((i + 1) << (KeyBits - depth)) - 1, low bits
  function automatic logic [KeyBits-1:0] node_last_key(input logic [NodeW-1:0] idx,
                                                       input logic [DepW-1:0] dep);
    logic [KeyBits-1:0] t;
    t = idx[KeyBits-1:0] + 1'b1;
    t = t << (KeyDep - dep);
    return t - 1'b1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/qde_node_ram.sv @@
// qde_node_ram: node store, one word per tree slot (present bit and count)
// one write and one registered read per cycle; uses qde_pkg
`default_nettype none

module qde_node_ram (
  input  wire logic              clk_i,
  input  wire qde_pkg::mem_req_t req_i,
  output qde_pkg::node_t         rd_data_o
);

  qde_pkg::node_t mem_q [qde_pkg::MemDepth];
  qde_pkg::node_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

@@ rtl/qde_div.sv @@
// qde_div: restoring divider, one quotient bit per cycle
// gives the merge threshold N div K; uses qde_pkg
`default_nettype none

module qde_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [qde_pkg::CntW-1:0]   dividend_i,
  input  wire logic [qde_pkg::KW-1:0]     divisor_i,
  output logic                            done_o,
  output logic [qde_pkg::CntW-1:0]        quotient_o
);

  logic                        busy_q, busy_d;
  logic [qde_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [qde_pkg::CntW-1:0]    dq_q, dq_d;
  logic [qde_pkg::KW-1:0]      rem_q, rem_d;
  logic [qde_pkg::KW-1:0]      dv_q, dv_d;
  logic [qde_pkg::KW:0]        rem_sh;
  logic                        fits;

  assign rem_sh = {rem_q, dq_q[qde_pkg::CntW-1]};
  assign fits   = rem_sh >= {1'b0, dv_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = qde_pkg::DivCntW'(qde_pkg::CntW);
      dq_d   = dividend_i;
      rem_d  = '0;
      dv_d   = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        dq_d  = {dq_q[qde_pkg::CntW-2:0], fits};
        rem_d = fits ? qde_pkg::KW'(rem_sh - {1'b0, dv_q}) : rem_sh[qde_pkg::KW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

@@ rtl/qde_walk.sv @@
// qde_walk: sequencer for inserts, compression pass and rank walk
// drives the node store port and the divider; uses qde_pkg
`default_nettype none

module qde_walk (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire qde_pkg::cmd_e                 cmd_i,
  input  wire logic [qde_pkg::KeyBits-1:0]   key_i,
  input  wire logic [qde_pkg::AmtW-1:0]      amount_i,
  input  wire logic [qde_pkg::FracW-1:0]     fraction_i,
  input  wire logic [qde_pkg::KW-1:0]        k_i,
  input  wire logic                          out_free_i,
  output logic                               idle_o,
  output logic                               done_o,
  output qde_pkg::result_t                   result_o,
  output qde_pkg::mem_req_t                  mem_req_o,
  input  wire qde_pkg::node_t                mem_rd_i,
  output logic                               div_start_o,
  output logic [qde_pkg::CntW-1:0]           div_dividend_o,
  output logic [qde_pkg::KW-1:0]             div_divisor_o,
  input  wire logic                          div_done_i,
  input  wire logic [qde_pkg::CntW-1:0]      div_quotient_i
);

  localparam int NW = qde_pkg::NodeW;
  localparam int CW = qde_pkg::CntW;

  qde_pkg::walk_state_e state_q, state_d;

  logic [NW-1:0]                cur_q, cur_d;
  logic [qde_pkg::DepW-1:0]     dep_q, dep_d;
  logic [qde_pkg::KeyBits-1:0]  kshift_q, kshift_d;
  logic [qde_pkg::AmtW-1:0]     amt_q, amt_d;
  logic [qde_pkg::FracW-1:0]    frac_q, frac_d;
  qde_pkg::cmd_e                mode_q, mode_d;
  logic [CW-1:0]                total_q, total_d;
  logic [NW-1:0]                ptot_q, ptot_d;
  logic [NW-1:0]                clr_q, clr_d;
  logic [CW-1:0]                thr_q, thr_d;
  logic [qde_pkg::ProdW-1:0]    prod_q, prod_d;
  logic [CW-1:0]                want_q, want_d;
  logic [qde_pkg::AccW-1:0]     acc_q, acc_d;
  qde_pkg::node_t               nw_q, nw_d;
  logic                         kl_q, kl_d;
  logic                         kids_q, kids_d;
  logic [CW-1:0]                pc_q, pc_d;
  qde_pkg::node_t               sw_q, sw_d;
  logic                         skl_q, skl_d;
  logic                         sk_q, sk_d;
  logic [qde_pkg::KeyBits-1:0]  pval_q, pval_d;
  logic                         comp_q, comp_d;

  logic [qde_pkg::KW-1:0]       keff;
  logic [qde_pkg::KsixW-1:0]    k6;
  logic                         not_leaf;
  logic [NW-1:0]                left_a, right_a, parent_a, sib_a, ins_a;
  logic [CW-1:0]                want_w, fam_sum;
  logic [qde_pkg::AccW-1:0]     acc_sum;
  logic                         kids_w, drop_w, merge_w, hit_w, need_comp;

  assign keff      = (k_i == '0) ? qde_pkg::KW'(1) : k_i;
  assign k6        = ({3'b000, keff} << 2) + ({3'b000, keff} << 1);
  assign need_comp = {{(qde_pkg::KsixW - NW){1'b0}}, ptot_q} >= k6;
  assign not_leaf  = dep_q != qde_pkg::KeyDep;
  assign left_a    = {cur_q[NW-2:0], 1'b0};
  assign right_a   = {cur_q[NW-2:0], 1'b1};
  assign parent_a  = {1'b0, cur_q[NW-1:1]};
  assign sib_a     = {cur_q[NW-1:1], ~cur_q[0]};
  assign ins_a     = {cur_q[NW-2:0], kshift_q[qde_pkg::KeyBits-1]};
  assign want_w    = prod_q[CW+15:16];
  assign acc_sum   = acc_q + {1'b0, mem_rd_i.cnt};
  assign hit_w     = (acc_sum >= {1'b0, want_q}) || (cur_q == NW'(1));
  assign kids_w    = kl_q || (mem_rd_i.pres && not_leaf);
  assign drop_w    = (nw_q.cnt == '0) && !kids_w;
  assign fam_sum   = qde_pkg::sat_add(qde_pkg::sat_add(pc_q, nw_q.cnt), sw_q.cnt);
  assign merge_w   = fam_sum < thr_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qde_pkg::ST_CLEAR:    if (clr_q == '1) state_d = qde_pkg::ST_IDLE;
      qde_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = (cmd_i == qde_pkg::CMD_QUERY) ? qde_pkg::ST_Q_MUL : qde_pkg::ST_INS_RD;
        end
      end
      qde_pkg::ST_INS_RD:   state_d = qde_pkg::ST_INS_CHK;
      qde_pkg::ST_INS_CHK:  if (!not_leaf) state_d = qde_pkg::ST_INS_END;
      qde_pkg::ST_INS_END:  state_d = need_comp ? qde_pkg::ST_DIV_GO : qde_pkg::ST_DONE;
      qde_pkg::ST_DIV_GO:   state_d = qde_pkg::ST_DIV_WAIT;
      qde_pkg::ST_DIV_WAIT: if (div_done_i) state_d = qde_pkg::ST_T_DOWN;
      qde_pkg::ST_Q_MUL:    state_d = qde_pkg::ST_Q_CHK;
      qde_pkg::ST_Q_CHK:    state_d = (want_w == '0) ? qde_pkg::ST_DONE : qde_pkg::ST_T_DOWN;
      qde_pkg::ST_T_DOWN:   state_d = not_leaf ? qde_pkg::ST_T_LCHK : qde_pkg::ST_T_VISIT;
      qde_pkg::ST_T_LCHK:   state_d = mem_rd_i.pres ? qde_pkg::ST_T_DOWN : qde_pkg::ST_T_RCHK;
      qde_pkg::ST_T_RCHK:   state_d = mem_rd_i.pres ? qde_pkg::ST_T_DOWN : qde_pkg::ST_T_VISIT;
      qde_pkg::ST_T_VISIT: begin
        if (mode_q == qde_pkg::CMD_QUERY) begin
          state_d = qde_pkg::ST_Q_ADD;
        end else begin
          state_d = (cur_q == NW'(1)) ? qde_pkg::ST_DONE : qde_pkg::ST_C_RL;
        end
      end
      qde_pkg::ST_Q_ADD:    state_d = hit_w ? qde_pkg::ST_DONE : qde_pkg::ST_T_UP;
      qde_pkg::ST_C_RL:     state_d = qde_pkg::ST_C_RR;
      qde_pkg::ST_C_RR:     state_d = qde_pkg::ST_C_DEC;
      qde_pkg::ST_C_DEC:    state_d = drop_w ? qde_pkg::ST_T_UP : qde_pkg::ST_C_PS;
      qde_pkg::ST_C_PS:     state_d = qde_pkg::ST_C_SK;
      qde_pkg::ST_C_SK:     state_d = qde_pkg::ST_C_SKL;
      qde_pkg::ST_C_SKL:    state_d = qde_pkg::ST_C_SUM;
      qde_pkg::ST_C_SUM:    state_d = merge_w ? qde_pkg::ST_C_WI : qde_pkg::ST_T_UP;
      qde_pkg::ST_C_WI:     state_d = qde_pkg::ST_C_WS;
      qde_pkg::ST_C_WS:     state_d = qde_pkg::ST_T_UP;
      qde_pkg::ST_T_UP: begin
        priority if (cur_q == NW'(1)) state_d = qde_pkg::ST_DONE;
        else if (!cur_q[0])           state_d = qde_pkg::ST_T_SCHK;
        else                          state_d = qde_pkg::ST_T_VISIT;
      end
      qde_pkg::ST_T_SCHK:   state_d = mem_rd_i.pres ? qde_pkg::ST_T_DOWN : qde_pkg::ST_T_VISIT;
      qde_pkg::ST_DONE:     if (out_free_i) state_d = qde_pkg::ST_IDLE;
      default:              state_d = qde_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    cur_d    = cur_q;
    dep_d    = dep_q;
    kshift_d = kshift_q;
    amt_d    = amt_q;
    frac_d   = frac_q;
    mode_d   = mode_q;
    total_d  = total_q;
    ptot_d   = ptot_q;
    clr_d    = clr_q;
    thr_d    = thr_q;
    prod_d   = prod_q;
    want_d   = want_q;
    acc_d    = acc_q;
    nw_d     = nw_q;
    kl_d     = kl_q;
    kids_d   = kids_q;
    pc_d     = pc_q;
    sw_d     = sw_q;
    skl_d    = skl_q;
    sk_d     = sk_q;
    pval_d   = pval_q;
    comp_d   = comp_q;
    mem_req_o   = '0;
    div_start_o = 1'b0;
    unique case (state_q)
      qde_pkg::ST_CLEAR: begin
        mem_req_o.wr_en        = 1'b1;
        mem_req_o.wr_addr      = clr_q;
        mem_req_o.wr_data.pres = (clr_q == NW'(1));
        clr_d = clr_q + 1'b1;
      end
      qde_pkg::ST_IDLE: begin
        if (start_i) begin
          cur_d    = NW'(1);
          dep_d    = '0;
          kshift_d = key_i;
          amt_d    = amount_i;
          frac_d   = (fraction_i > qde_pkg::FracOne) ? qde_pkg::FracOne : fraction_i;
          mode_d   = cmd_i;
          pval_d   = '0;
          comp_d   = 1'b0;
        end
      end
      qde_pkg::ST_INS_RD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = ins_a;
        cur_d    = ins_a;
        dep_d    = dep_q + 1'b1;
        kshift_d = kshift_q << 1;
      end
      qde_pkg::ST_INS_CHK: begin
        mem_req_o.wr_addr = cur_q;
        if (!mem_rd_i.pres) ptot_d = ptot_q + 1'b1;
        if (!not_leaf) begin
          mem_req_o.wr_en        = 1'b1;
          mem_req_o.wr_data.pres = 1'b1;
          mem_req_o.wr_data.cnt  = qde_pkg::sat_add(mem_rd_i.pres ? mem_rd_i.cnt : '0,
                                                    {{(CW - qde_pkg::AmtW){1'b0}}, amt_q});
          total_d = qde_pkg::sat_add(total_q, {{(CW - qde_pkg::AmtW){1'b0}}, amt_q});
        end else begin
          // create the missing inner node, fetch the next one down the path
          mem_req_o.wr_en        = !mem_rd_i.pres;
          mem_req_o.wr_data.pres = 1'b1;
          mem_req_o.rd_en        = 1'b1;
          mem_req_o.rd_addr      = ins_a;
          cur_d    = ins_a;
          dep_d    = dep_q + 1'b1;
          kshift_d = kshift_q << 1;
        end
      end
      qde_pkg::ST_INS_END: begin
        comp_d = need_comp;
      end
      qde_pkg::ST_DIV_GO: begin
        div_start_o = 1'b1;
      end
      qde_pkg::ST_DIV_WAIT: begin
        thr_d  = div_quotient_i;
        cur_d  = NW'(1);
        dep_d  = '0;
        mode_d = qde_pkg::CMD_INSERT;
      end
      qde_pkg::ST_Q_MUL: begin
        prod_d = {{(qde_pkg::ProdW - qde_pkg::FracW){1'b0}}, frac_q}
               * {{(qde_pkg::ProdW - CW){1'b0}}, total_q};
      end
      qde_pkg::ST_Q_CHK: begin
        want_d = want_w;
        acc_d  = '0;
      end
      qde_pkg::ST_T_DOWN: begin
        mem_req_o.rd_en   = not_leaf;
        mem_req_o.rd_addr = left_a;
      end
      qde_pkg::ST_T_LCHK: begin
        if (mem_rd_i.pres) begin
          cur_d = left_a;
          dep_d = dep_q + 1'b1;
        end else begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = right_a;
        end
      end
      qde_pkg::ST_T_RCHK: begin
        if (mem_rd_i.pres) begin
          cur_d = right_a;
          dep_d = dep_q + 1'b1;
        end
      end
      qde_pkg::ST_T_VISIT: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = cur_q;
      end
      qde_pkg::ST_Q_ADD: begin
        acc_d = acc_sum;
        if (hit_w) pval_d = qde_pkg::node_last_key(cur_q, dep_q);
      end
      qde_pkg::ST_C_RL: begin
        nw_d = mem_rd_i;
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = left_a;
      end
      qde_pkg::ST_C_RR: begin
        kl_d = mem_rd_i.pres && not_leaf;
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = right_a;
      end
      qde_pkg::ST_C_DEC: begin
        kids_d = kids_w;
        if (drop_w) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = cur_q;
          ptot_d = ptot_q - 1'b1;
        end else begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = parent_a;
        end
      end
      qde_pkg::ST_C_PS: begin
        pc_d = mem_rd_i.cnt;
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = sib_a;
      end
      qde_pkg::ST_C_SK: begin
        sw_d = mem_rd_i;
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = {sib_a[NW-2:0], 1'b0};
      end
      qde_pkg::ST_C_SKL: begin
        skl_d = mem_rd_i.pres && not_leaf;
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = {sib_a[NW-2:0], 1'b1};
      end
      qde_pkg::ST_C_SUM: begin
        sk_d = skl_q || (mem_rd_i.pres && not_leaf);
        if (merge_w) begin
          mem_req_o.wr_en        = 1'b1;
          mem_req_o.wr_addr      = parent_a;
          mem_req_o.wr_data.pres = 1'b1;
          mem_req_o.wr_data.cnt  = fam_sum;
        end
      end
      qde_pkg::ST_C_WI: begin
        mem_req_o.wr_en        = 1'b1;
        mem_req_o.wr_addr      = cur_q;
        mem_req_o.wr_data.pres = kids_q;
        if (!kids_q) ptot_d = ptot_q - 1'b1;
      end
      qde_pkg::ST_C_WS: begin
        if (sw_q.pres) begin
          mem_req_o.wr_en        = 1'b1;
          mem_req_o.wr_addr      = sib_a;
          mem_req_o.wr_data.pres = sk_q;
          if (!sk_q) ptot_d = ptot_q - 1'b1;
        end
      end
      qde_pkg::ST_T_UP: begin
        if (cur_q != NW'(1)) begin
          if (!cur_q[0]) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = sib_a;
          end else begin
            cur_d = parent_a;
            dep_d = dep_q - 1'b1;
          end
        end
      end
      qde_pkg::ST_T_SCHK: begin
        if (mem_rd_i.pres) begin
          cur_d = sib_a;
        end else begin
          cur_d = parent_a;
          dep_d = dep_q - 1'b1;
        end
      end
      qde_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qde_pkg::ST_CLEAR;
      total_q <= '0;
      ptot_q  <= NW'(1);
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ptot_q  <= ptot_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    dep_q    <= dep_d;
    kshift_q <= kshift_d;
    amt_q    <= amt_d;
    frac_q   <= frac_d;
    mode_q   <= mode_d;
    thr_q    <= thr_d;
    prod_q   <= prod_d;
    want_q   <= want_d;
    acc_q    <= acc_d;
    nw_q     <= nw_d;
    kl_q     <= kl_d;
    kids_q   <= kids_d;
    pc_q     <= pc_d;
    sw_q     <= sw_d;
    skl_q    <= skl_d;
    sk_q     <= sk_d;
    pval_q   <= pval_d;
    comp_q   <= comp_d;
  end

  assign idle_o          = state_q == qde_pkg::ST_IDLE;
  assign done_o          = (state_q == qde_pkg::ST_DONE) && out_free_i;
  assign result_o.pval   = pval_q;
  assign result_o.total  = total_q;
  assign result_o.nodes  = ptot_q;
  assign result_o.comp   = comp_q;
  assign div_dividend_o  = total_q;
  assign div_divisor_o   = keff;

endmodule

`default_nettype wire

@@ rtl/quantile_digest_engine.sv @@
// quantile_digest_engine: q-digest quantile sketch over a 2^KeyBits key universe
// top level; instantiates qde_walk, qde_node_ram and qde_div, uses qde_pkg
`default_nettype none
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------------
//  in       | sink      | in_valid_i / in_ready_o    | command, key, amount, fraction
//  out      | source    | out_valid_o / out_ready_i  | percentile_value, total_count,
//           |           |                            | node_total, compressed
//  cfg      | sink      | cfg_valid_i / cfg_ready_o  | cfg_data_i (compression factor K)
//
//  one item is worked on at a time; all tree state lives in a 2048-word node store
//  with one read and one write port, so each step is a few store accesses
//  insert: one store read per tree level
//  compression: a divider run for the merge threshold, then a walk over the present nodes
//  query: the rank product, then a walk over present nodes until the rank is reached
//  after reset a clearing pass sweeps the store; in_ready_o stays low
//  a finished result waits in the output register; a new item is taken meanwhile

module quantile_digest_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          command_i,
  input  wire logic [qde_pkg::KeyBits-1:0]   key_i,
  input  wire logic [qde_pkg::AmtW-1:0]      amount_i,
  input  wire logic [qde_pkg::FracW-1:0]     fraction_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [qde_pkg::KeyBits-1:0]        percentile_value_o,
  output logic [qde_pkg::CntW-1:0]           total_count_o,
  output logic [qde_pkg::NodeW-1:0]          node_total_o,
  output logic                               compressed_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [qde_pkg::KW-1:0]        cfg_data_i
);

  // compression factor register, written only while the engine is idle
  logic [qde_pkg::KW-1:0] k_q, k_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  qde_pkg::result_t        res_q, res_d;

  // walk sequencer links
  logic                    idle, done, out_free, start;
  qde_pkg::result_t        result;
  qde_pkg::mem_req_t       mem_req;
  qde_pkg::node_t          mem_rd;
  logic                    div_start, div_done;
  logic [qde_pkg::CntW-1:0] div_dividend, div_quotient;
  logic [qde_pkg::KW-1:0]  div_divisor;

  assign cfg_ready_o = idle;
  assign k_d         = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : k_q;

  assign in_ready_o  = idle;
  assign start       = in_valid_i && in_ready_o;
  // the output slot frees up in the same cycle its result is taken
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (done) begin
      out_valid_d = 1'b1;
      res_d       = result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= qde_pkg::KReset;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  qde_walk u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cmd_i          (qde_pkg::cmd_e'(command_i)),
    .key_i          (key_i),
    .amount_i       (amount_i),
    .fraction_i     (fraction_i),
    .k_i            (k_q),
    .out_free_i     (out_free),
    .idle_o         (idle),
    .done_o         (done),
    .result_o       (result),
    .mem_req_o      (mem_req),
    .mem_rd_i       (mem_rd),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quotient_i (div_quotient)
  );

  qde_node_ram u_node_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

  qde_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign out_valid_o        = out_valid_q;
  assign percentile_value_o = res_q.pval;
  assign total_count_o      = res_q.total;
  assign node_total_o       = res_q.nodes;
  assign compressed_o       = res_q.comp;

`ifndef ASSERT_OFF
  // the root is never removed
  a_root_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> node_total_o != '0)
    else $error("node total reached zero");

  // a compressing insert reports no percentile
  a_comp_pval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && compressed_o) |-> percentile_value_o == '0)
    else $error("compression result carries a percentile");

  // one item at a time: after an input transfer no further item is taken next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while busy");

  // a new result only appears while an item was in flight
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without an item in flight");
`endif

endmodule

`default_nettype wire
